FILE: rtl/led_pwm_effect_engine_defines.svh
// Assertion macros used by the engine's top-level RTL.
// Define NO_ASSERTIONS to drop every check.
`ifndef LED_PWM_EFFECT_ENGINE_DEFINES_SVH
`define LED_PWM_EFFECT_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define LPE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("led_pwm_effect_engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("led_pwm_effect_engine: next-cycle check failed");

`else

`define LPE_ASSERT_SAME(label, ante, cons)
`define LPE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/lpe_pkg.sv
package lpe_pkg;

  // Brightness is held in at least 18 signed bits and saturates to that range.
  localparam int BRIGHT_BITS = 18;
  localparam int BRIGHT_MAX  = 131071;
  localparam int BRIGHT_MIN  = -131072;

  // Configuration register file.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PWM_PERIOD   = 3'd0,
    REG_TICK_MS      = 3'd1,
    REG_BREATH_STEP  = 3'd2,
    REG_FLASH_LEVEL  = 3'd3,
    REG_FLASH_GROUPS = 3'd4,
    REG_FLASH_ON_MS  = 3'd5,
    REG_FLASH_OFF_MS = 3'd6,
    REG_FLASH_GAP_MS = 3'd7
  } lpe_reg_t;

  // Per-channel effect modes.
  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_FULL    = 2'd1,
    MODE_BREATHE = 2'd2,
    MODE_FLASH   = 2'd3
  } lpe_mode_t;

  // Word kinds.
  localparam logic KIND_PWM    = 1'b0;
  localparam logic KIND_EFFECT = 1'b1;

  typedef struct packed {
    logic [7:0]  pwm_period;
    logic [9:0]  tick_ms;
    logic [15:0] breath_step;
    logic [7:0]  flash_level;
    logic [7:0]  flash_groups;
    logic [15:0] flash_on_ms;
    logic [15:0] flash_off_ms;
    logic [15:0] flash_gap_ms;
  } lpe_cfg_t;

  // Control for the channel units on an accepted word.
  typedef struct packed {
    logic fire;    // a word is accepted this cycle
    logic effect;  // the word is an effect tick
    logic clear;   // mode vector changed: clear brightness and flash counters
  } lpe_step_t;

endpackage

FILE: rtl/lpe_chan.sv
module lpe_chan import lpe_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  lpe_cfg_t  cfg,
  input  lpe_step_t step,
  input  lpe_mode_t mode,
  input  logic [7:0] pwm_count,
  output logic      lit,
  output logic      done
);

  localparam int BW = (FRACTION_BITS + 9 > BRIGHT_BITS) ? FRACTION_BITS + 9 : BRIGHT_BITS;
  localparam int SW = BW + 2;
  localparam logic signed [SW-1:0] SAT_HI = SW'(BRIGHT_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(BRIGHT_MIN);

  logic signed [BW-1:0] bright_r, bright_nxt, bright_cur;
  logic                 fall_r, fall_nxt;
  logic [15:0]          ms_r, ms_nxt, ms_cur, ms_base;
  logic [7:0]           grp_r, grp_nxt, grp_cur;
  logic signed [BW-1:0] top_s, flash_s, level_s;
  logic signed [SW-1:0] up_sum, dn_sum, up_sat, dn_sat;
  logic signed [BW-1:0] up_val, dn_val;
  logic [16:0]          flash_period, ms_sum;

  // Scaled constants for this channel's comparisons.
  assign top_s   = $signed(BW'(cfg.pwm_period) << FRACTION_BITS);
  assign flash_s = $signed(BW'(cfg.flash_level) << FRACTION_BITS);
  assign level_s = $signed(BW'(pwm_count) << FRACTION_BITS);
  assign flash_period = {1'b0, cfg.flash_on_ms} + {1'b0, cfg.flash_off_ms};

  // A change of the mode vector clears everything but the breathing direction.
  assign bright_cur = step.clear ? '0 : bright_r;
  assign ms_cur     = step.clear ? '0 : ms_r;
  assign grp_cur    = step.clear ? '0 : grp_r;

  // Breathing ramp in both directions, saturated to the brightness range.
  assign up_sum = SW'(bright_cur) + $signed(SW'(cfg.breath_step));
  assign dn_sum = SW'(bright_cur) - $signed(SW'(cfg.breath_step));
  assign up_sat = (up_sum > SAT_HI) ? SAT_HI : ((up_sum < SAT_LO) ? SAT_LO : up_sum);
  assign dn_sat = (dn_sum > SAT_HI) ? SAT_HI : ((dn_sum < SAT_LO) ? SAT_LO : dn_sum);
  assign up_val = BW'(up_sat);
  assign dn_val = BW'(dn_sat);

  // Effect update for one effect tick.
  always_comb begin
    bright_nxt = bright_cur;
    fall_nxt   = fall_r;
    ms_nxt     = ms_cur;
    grp_nxt    = grp_cur;
    ms_base    = ms_cur;
    ms_sum     = '0;
    done       = 1'b0;
    case (mode)
      MODE_OFF: begin
        bright_nxt = '0;
      end
      MODE_FULL: begin
        bright_nxt = top_s;
      end
      MODE_BREATHE: begin
        if (!fall_r) begin
          bright_nxt = up_val;
          if (up_val > top_s) begin
            fall_nxt = 1'b1;
          end
        end else begin
          bright_nxt = dn_val;
          if (dn_val < 0) begin
            fall_nxt = 1'b0;
            done     = 1'b1;
          end
        end
      end
      default: begin
        // Flash: groups of on and off time, then a dark gap.
        if (grp_cur < cfg.flash_groups) begin
          if ({1'b0, ms_cur} < {1'b0, cfg.flash_on_ms}) begin
            bright_nxt = flash_s;
          end else if ({1'b0, ms_cur} < flash_period) begin
            bright_nxt = '0;
          end
          if ({1'b0, ms_cur} >= flash_period) begin
            grp_nxt = grp_cur + 8'd1;
            ms_base = '0;
          end
        end else if (ms_cur < cfg.flash_gap_ms) begin
          bright_nxt = '0;
        end else begin
          grp_nxt = '0;
          ms_base = '0;
          done    = 1'b1;
        end
        ms_sum = {1'b0, ms_base} + 17'(cfg.tick_ms);
        ms_nxt = ms_sum[16] ? 16'hFFFF : ms_sum[15:0];
      end
    endcase
  end

  // An effect tick shows the new brightness, a PWM tick the stored one.
  assign lit = step.effect ? (level_s < bright_nxt) : (level_s < bright_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= '0;
      fall_r   <= 1'b0;
      ms_r     <= '0;
      grp_r    <= '0;
    end else if (step.fire && step.effect) begin
      bright_r <= bright_nxt;
      fall_r   <= fall_nxt;
      ms_r     <= ms_nxt;
      grp_r    <= grp_nxt;
    end
  end

endmodule

FILE: rtl/lpe_obuf.sv
module lpe_obuf import lpe_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         out_valid,
  output logic [W-1:0] out_data,
  input  logic         out_stall
);

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  logic [W-1:0] out_data_r, skid_data_r;
  logic         out_free;

  // The output word is free when empty or taken this cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      out_valid_nxt  = skid_valid_r || push;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload moves: skid to output first, else the new word lands where there is room.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/led_pwm_effect_engine.sv
// Channel  | Direction | Handshake            | Payload
// in       | input     | in_valid / in_stall  | in_kind, in_channel_modes
// out      | output    | out_valid / out_stall| out_led_on, out_cycle_done
// cfg      | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
// One word is accepted per cycle while in_stall is low; its result is registered in the output buffer.
// Channel state and the PWM counter update at the accepting edge in a single pass.
// A two-entry output buffer (output register plus skid) decouples the sides;
// in_stall rises only once both entries hold words.
// Reset is synchronous, active low, and restores the configuration, the channel state
// and the buffer's valid flags; the buffered payload is not reset.
`include "led_pwm_effect_engine_defines.svh"

module led_pwm_effect_engine import lpe_pkg::*; #(
  parameter int CHANNELS      = 4,
  parameter int FRACTION_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [2*CHANNELS-1:0]     in_channel_modes,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHANNELS-1:0]       out_led_on,
  output logic [CHANNELS-1:0]       out_cycle_done,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  lpe_cfg_t                cfg_r;
  logic [7:0]              pwm_count_r, pwm_count_nxt;
  logic [8:0]              pwm_inc;
  logic [2*CHANNELS-1:0]   prev_modes_r;
  lpe_step_t               step;
  logic                    in_fire;
  logic [CHANNELS-1:0]     lit, done;
  logic [2*CHANNELS-1:0]   res_word, out_word;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period   <= 8'd20;
      cfg_r.tick_ms      <= 10'd50;
      cfg_r.breath_step  <= 16'd256;
      cfg_r.flash_level  <= 8'd16;
      cfg_r.flash_groups <= 8'd2;
      cfg_r.flash_on_ms  <= 16'd100;
      cfg_r.flash_off_ms <= 16'd100;
      cfg_r.flash_gap_ms <= 16'd500;
    end else if (cfg_wr_en) begin
      unique case (lpe_reg_t'(cfg_index))
        REG_PWM_PERIOD:   cfg_r.pwm_period   <= cfg_wdata[7:0];
        REG_TICK_MS:      cfg_r.tick_ms      <= cfg_wdata[9:0];
        REG_BREATH_STEP:  cfg_r.breath_step  <= cfg_wdata;
        REG_FLASH_LEVEL:  cfg_r.flash_level  <= cfg_wdata[7:0];
        REG_FLASH_GROUPS: cfg_r.flash_groups <= cfg_wdata[7:0];
        REG_FLASH_ON_MS:  cfg_r.flash_on_ms  <= cfg_wdata;
        REG_FLASH_OFF_MS: cfg_r.flash_off_ms <= cfg_wdata;
        REG_FLASH_GAP_MS: cfg_r.flash_gap_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accepted word and the control it sends to the channels.
  assign in_fire     = in_valid && !in_stall;
  assign step.fire   = in_fire;
  assign step.effect = (in_kind == KIND_EFFECT);
  assign step.clear  = (in_channel_modes != prev_modes_r);

  // Shared PWM counter, wrapping at the period.
  assign pwm_inc       = {1'b0, pwm_count_r} + 9'd1;
  assign pwm_count_nxt = (pwm_inc >= {1'b0, cfg_r.pwm_period}) ? 8'd0 : pwm_inc[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_count_r  <= '0;
      prev_modes_r <= '0;
    end else if (in_fire) begin
      if (in_kind == KIND_PWM) begin
        pwm_count_r <= pwm_count_nxt;
      end else begin
        prev_modes_r <= in_channel_modes;
      end
    end
  end

  // One effect unit per channel.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    lpe_chan #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cfg_r),
      .step      (step),
      .mode      (lpe_mode_t'(in_channel_modes[2*c +: 2])),
      .pwm_count (pwm_count_r),
      .lit       (lit[c]),
      .done      (done[c])
    );
  end

  // A PWM tick never reports a finished cycle.
  assign res_word = {lit, step.effect ? done : {CHANNELS{1'b0}}};

  lpe_obuf #(
    .W (2*CHANNELS)
  ) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res_word),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_data  (out_word),
    .out_stall (out_stall)
  );

  assign out_led_on     = out_word[2*CHANNELS-1:CHANNELS];
  assign out_cycle_done = out_word[CHANNELS-1:0];

  // A full skid entry always sits behind a valid output word.
  `LPE_ASSERT_SAME(a_skid_behind_out, in_stall, out_valid)
  // Every accepted word leaves a valid output word.
  `LPE_ASSERT_NEXT(a_fire_gives_out, in_fire, out_valid)
  // After a PWM tick the counter is below the period it was compared with.
  `LPE_ASSERT_NEXT(a_pwm_wrap, in_fire && (in_kind == KIND_PWM) && (cfg_r.pwm_period != 8'd0),
                   pwm_count_r < $past(cfg_r.pwm_period))
  // A PWM tick landing in an empty output reports no finished cycles.
  `LPE_ASSERT_NEXT(a_pwm_no_done, in_fire && (in_kind == KIND_PWM) && !out_valid,
                   out_cycle_done == '0)

endmodule
